>>> rtl/core/lcc_pkg.sv
// Shared types, constants and helpers of the Luhn card number classifier.
`timescale 1ns / 1ps

package lcc_pkg;

  localparam int NUM_W         = 63;
  localparam int BCD_DIGITS    = 19;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int CNT_W         = 5;
  localparam int STEP_BITS_DEF = 4;

  localparam logic [3:0] DEC_BASE = 4'd10;

  localparam logic [6:0] PFX15_A  = 7'd34;
  localparam logic [6:0] PFX15_B  = 7'd37;
  localparam logic [6:0] PFX16_LO = 7'd51;
  localparam logic [6:0] PFX16_HI = 7'd55;
  localparam logic [3:0] LEAD_4   = 4'd4;

  localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [CNT_W-1:0] LEN_16 = 5'd16;
  localparam logic [CNT_W-1:0] LEN_MAX = 5'd19;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_LEN15   = 2'd1,
    CLS_LEN16_5 = 2'd2,
    CLS_LEAD4   = 2'd3
  } issuer_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } dab_ctl_t;

  typedef struct packed {
    logic clear;
    logic acc;
  } luhn_ctl_t;

  // sum of the decimal digits of twice d
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/lcc_dabble.sv
// Shift-and-add-3 binary to BCD unit, then a digit shifter for the scan.
`timescale 1ns / 1ps

module lcc_dabble #(
  parameter int STEP_BITS = lcc_pkg::STEP_BITS_DEF
) (
  input  logic                     clk,
  input  lcc_pkg::dab_ctl_t        ctl,
  input  logic [lcc_pkg::NUM_W-1:0] in_num,
  output logic [3:0]               digit,
  output logic                     bcd_zero
);
  import lcc_pkg::*;

  localparam int PAD_W = ((NUM_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;

  logic [PAD_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [PAD_W-1:0] bin_v;
  logic [BCD_W-1:0] bcd_v;

  always_comb begin
    bcd_v = bcd_r;
    bin_v = bin_r;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (bcd_v[4*k +: 4] >= 4'd5) begin
          bcd_v[4*k +: 4] = bcd_v[4*k +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bin_r <= PAD_W'(in_num);
      bcd_r <= '0;
    end else if (ctl.conv) begin
      bin_r <= bin_v;
      bcd_r <= bcd_v;
    end else if (ctl.shift) begin
      bcd_r <= {4'd0, bcd_r[BCD_W-1:4]};
    end
  end

  assign digit    = bcd_r[3:0];
  assign bcd_zero = (bcd_r == '0);

endmodule

>>> rtl/core/lcc_luhn.sv
// Luhn digit accumulator: running sum mod 10, digit count and leading digits.
`timescale 1ns / 1ps

module lcc_luhn (
  input  logic                      clk,
  input  lcc_pkg::luhn_ctl_t        ctl,
  input  logic [3:0]                digit,
  output logic                      sum_zero,
  output logic [lcc_pkg::CNT_W-1:0] count,
  output logic [3:0]                lead,
  output logic [6:0]                lead2
);
  import lcc_pkg::*;

  logic [3:0]       sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]       lead_r;
  logic [3:0]       prev_r;
  logic [3:0]       add;
  logic [4:0]       s;
  logic [3:0]       sum_nxt;

  always_comb begin
    add = cnt_r[0] ? luhn_dbl(digit) : digit;
    s   = {1'b0, sum_r} + {1'b0, add};
    if (s >= {1'b0, DEC_BASE}) begin
      sum_nxt = 4'(s - {1'b0, DEC_BASE});
    end else begin
      sum_nxt = s[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      lead_r <= '0;
      prev_r <= '0;
    end else if (ctl.acc) begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_r + 1'b1;
      lead_r <= digit;
      prev_r <= lead_r;
    end
  end

  assign sum_zero = (sum_r == '0);
  assign count    = cnt_r;
  assign lead     = lead_r;
  assign lead2    = {lead_r, 3'b000} + {2'b00, lead_r, 1'b0} + {3'b000, prev_r};

endmodule

>>> rtl/core/luhn_card_number_classifier.sv
// Luhn card number classifier: sequencer, result register and top-level ports.
//
// Usage: one card number enters on the in_ channel per transaction; one result
// (issuer_class, checksum_ok, digit_count) leaves on the out_ channel.
// in_stall is low only while the sequencer is idle; one number is worked on at
// a time. The number is first converted to BCD by a shift-and-add-3 unit
// handling STEP_BITS bits per cycle, then the digits are scanned one per cycle
// from the least significant end through the Luhn accumulator, plus a
// closing step. Acceptance is followed by the conversion, the digit scan and
// the closing step, and then out_valid rises; the next number may be taken
// on the following cycle.
// The result sits in an output register, so a new number is accepted while a
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds in its closing cycle until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; no item or result survives it.
`timescale 1ns / 1ps

module luhn_card_number_classifier #(
  parameter int STEP_BITS = lcc_pkg::STEP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lcc_pkg::NUM_W-1:0] in_card_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_issuer_class,
  output logic                      out_checksum_ok,
  output logic [lcc_pkg::CNT_W-1:0] out_digit_count
);
  import lcc_pkg::*;

  localparam int PAD_W   = ((NUM_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS   = PAD_W / STEP_BITS;
  localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_CW-1:0] STEP_LAST = STEP_CW'(STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN
  } state_t;

  state_t           state_r, state_nxt;
  logic [STEP_CW-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       cls_r, cls_nxt;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] cnt_out_r, cnt_out_nxt;

  dab_ctl_t         dctl;
  luhn_ctl_t        lctl;
  logic [3:0]       digit;
  logic             bcd_zero;
  logic             sum_zero;
  logic [CNT_W-1:0] count;
  logic [3:0]       lead;
  logic [6:0]       lead2;
  logic             in_take;
  logic             finish;
  issuer_t          cls_c;

  assign in_take = in_valid && (state_r == S_IDLE);
  assign finish  = (state_r == S_SCAN) && bcd_zero && !(out_valid_r && out_stall);

  always_comb begin
    dctl.load  = in_take;
    dctl.conv  = (state_r == S_CONV);
    dctl.shift = (state_r == S_SCAN) && !bcd_zero;
    lctl.clear = in_take;
    lctl.acc   = (state_r == S_SCAN) && !bcd_zero;
  end

  lcc_dabble #(
    .STEP_BITS (STEP_BITS)
  ) u_dabble (
    .clk      (clk),
    .ctl      (dctl),
    .in_num   (in_card_number),
    .digit    (digit),
    .bcd_zero (bcd_zero)
  );

  lcc_luhn u_luhn (
    .clk      (clk),
    .ctl      (lctl),
    .digit    (digit),
    .sum_zero (sum_zero),
    .count    (count),
    .lead     (lead),
    .lead2    (lead2)
  );

  always_comb begin
    cls_c = CLS_NONE;
    if (sum_zero) begin
      if (count == LEN_15 && (lead2 == PFX15_A || lead2 == PFX15_B)) begin
        cls_c = CLS_LEN15;
      end else if (count == LEN_16 && (lead2 inside {[PFX16_LO:PFX16_HI]})) begin
        cls_c = CLS_LEN16_5;
      end else if ((count == LEN_16 || count == LEN_13) && lead == LEAD_4) begin
        cls_c = CLS_LEAD4;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cls_nxt       = cls_r;
    ok_nxt        = ok_r;
    cnt_out_nxt   = cnt_out_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CONV;
          step_nxt  = '0;
        end
      end
      S_CONV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          cls_nxt       = cls_c;
          ok_nxt        = sum_zero;
          cnt_out_nxt   = count;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cls_r     <= cls_nxt;
    ok_r      <= ok_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_issuer_class = cls_r;
  assign out_checksum_ok  = ok_r;
  assign out_digit_count  = cnt_out_r;

`ifndef ASSERT_OFF
  a_take_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CONV && step_r == '0))
    else $error("accepted transaction did not start conversion");

  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issuer_class != CLS_NONE) |-> out_checksum_ok)
    else $error("issuer class given with failed checksum");

  a_class_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issuer_class != CLS_NONE) |->
      (out_digit_count == LEN_13 || out_digit_count == LEN_15 ||
       out_digit_count == LEN_16))
    else $error("issuer class given at a length without a rule");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count <= LEN_MAX))
    else $error("digit count beyond nineteen");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digit_count)))
    else $error("waiting result overwritten");
`endif

endmodule
